>>> sv/mbp_pkg.sv
`timescale 1ns / 1ps
package mbp_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int BYTE_BITS   = 8;
  localparam int ACC_BITS    = VALUE_BITS + BYTE_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ALIGN = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // up to four finished bytes, first one in the top byte
  typedef struct packed {
    logic [VALUE_BITS-1:0] bytes;
    logic [2:0]            cnt;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

endpackage

>>> sv/mbp_if.sv
`timescale 1ns / 1ps
interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] field_value;
  logic [5:0]  field_width;

  modport source (output valid, kind, field_value, field_width, input ready);
  modport sink (input valid, kind, field_value, field_width, output ready);
endinterface

interface mbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

>>> sv/mbp_front.sv
`timescale 1ns / 1ps
module mbp_front
  import mbp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [VALUE_BITS-1:0] in_field_value,
  input  logic [5:0]            in_field_width,
  input  logic                  q_full,
  output job_req_t              push
);

  localparam int          LIM_I = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
  localparam logic [5:0]  LIM   = 6'(LIM_I);

  logic [BYTE_BITS-1:0] partial_r, partial_nxt;
  logic [2:0]           fill_r, fill_nxt;

  logic                  accept;
  logic [5:0]            w;
  logic [VALUE_BITS-1:0] v_m;
  logic [5:0]            total;
  logic [5:0]            sh;
  logic [ACC_BITS-1:0]   acc;
  logic [ACC_BITS-1:0]   rest;
  logic [2:0]            nb;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w     = (in_field_width > LIM) ? LIM : in_field_width;
    v_m   = (w == 6'(VALUE_BITS)) ? in_field_value
                                  : (in_field_value & ((32'd1 << w) - 32'd1));
    total = 6'(fill_r) + w;
    // place the new field right below the bits already held
    sh    = 6'(ACC_BITS) - total;
    acc   = {partial_r, {VALUE_BITS{1'b0}}} | (ACC_BITS'(v_m) << sh);
    nb    = total[5:3];
    rest  = acc << {nb, 3'b000};
  end

  always_comb begin
    partial_nxt    = partial_r;
    fill_nxt       = fill_r;
    push.valid     = 1'b0;
    push.job.bytes = acc[ACC_BITS-1:BYTE_BITS];
    push.job.cnt   = nb;
    if (accept) begin
      case (in_kind)
        KIND_WRITE: begin
          partial_nxt = rest[ACC_BITS-1:VALUE_BITS];
          fill_nxt    = total[2:0];
          push.valid  = (nb != 3'd0);
        end
        KIND_ALIGN: begin
          partial_nxt    = '0;
          fill_nxt       = '0;
          push.valid     = (fill_r != 3'd0);
          push.job.bytes = {partial_r, {(VALUE_BITS-BYTE_BITS){1'b0}}};
          push.job.cnt   = 3'd1;
        end
        KIND_CLEAR: begin
          partial_nxt = '0;
          fill_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= '0;
    end else begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

>>> sv/mbp_queue.sv
`timescale 1ns / 1ps
module mbp_queue
  import mbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t push,
  output logic     full,
  output job_req_t head,
  input  logic     pop
);

  job_t                 slots_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt;
  logic [QPTR_BITS-1:0] rd_r, rd_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full       = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = slots_r[rd_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/mbp_back.sv
`timescale 1ns / 1ps
module mbp_back
  import mbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  job_req_t             head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_BITS-1:0] out_byte,
  output logic                 out_last
);

  logic [VALUE_BITS-1:0] cur_r, cur_nxt;
  logic [1:0]            rem_r, rem_nxt;
  logic                  valid_r, valid_nxt;
  logic [BYTE_BITS-1:0]  byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic                  slot_free;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

  always_comb begin
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (slot_free) begin
      if (rem_r != 2'd0) begin
        // rest of the current job first
        byte_nxt  = cur_r[VALUE_BITS-1 -: BYTE_BITS];
        cur_nxt   = cur_r << BYTE_BITS;
        rem_nxt   = rem_r - 2'd1;
        last_nxt  = (rem_r == 2'd1);
        valid_nxt = 1'b1;
      end else if (head.valid) begin
        pop       = 1'b1;
        byte_nxt  = head.job.bytes[VALUE_BITS-1 -: BYTE_BITS];
        cur_nxt   = head.job.bytes << BYTE_BITS;
        rem_nxt   = 2'(head.job.cnt - 3'd1);
        last_nxt  = (head.job.cnt == 3'd1);
        valid_nxt = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      rem_r   <= rem_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> sv/msb_first_bit_packer.sv
`timescale 1ns / 1ps
// channel  | dir | handshake     | payload
// in_ch    | in  | valid / ready | kind[1:0], field_value[31:0], field_width[5:0]
// out_ch   | out | valid / ready | out_byte[7:0], last_of_run
//
// the back end sends one byte per cycle while out_ch.ready is high, and a
// write completes up to four bytes
// a four-entry job queue sits between the bit merger and the byte sender
// reset is synchronous and empties the partial byte, queue and output register
// in_ch.ready drops only while the job queue is full
module msb_first_bit_packer
  import mbp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  mbp_in_if.sink           in_ch,
  mbp_out_if.source        out_ch
);

  job_req_t push;
  job_req_t head;
  logic     q_full;
  logic     pop;

  mbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_kind       (in_ch.kind),
    .in_field_value(in_ch.field_value),
    .in_field_width(in_ch.field_width),
    .q_full        (q_full),
    .push          (push)
  );

  mbp_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  mbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_byte (out_ch.out_byte),
    .out_last (out_ch.last_of_run)
  );

endmodule

>>> sv/mbp_checker.sv
`timescale 1ns / 1ps
module mbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled byte stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("out payload changed while stalled");

  // input back-pressure only comes from queued bytes waiting behind the output
  a_ready_low_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no byte offered");

  // output stays quiet in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid right after reset");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_byte (out_ch.out_byte),
  .out_last (out_ch.last_of_run)
);
